// ===== rtl/core/sdpg_pkg.sv =====
// ---------------------------------------------------------------------------
// Spectrum display pixel generator package
// Action codes, screen geometry and the pixel stage record shared by the
// display generator.
// ---------------------------------------------------------------------------
package sdpg_pkg;

   typedef enum logic [1:0] {
      ACT_MEM_WRITE    = 2'd0,
      ACT_BORDER_WRITE = 2'd1,
      ACT_FRAME_END    = 2'd2,
      ACT_PIXEL        = 2'd3
   } action_type;

   localparam int unsigned AREA_W     = 256;
   localparam int unsigned AREA_H     = 192;
   localparam int unsigned VRAM_SIZE  = 6912;
   localparam int unsigned ATTR_BASE  = 6144;
   localparam int unsigned ATTR_SIZE  = VRAM_SIZE - ATTR_BASE;
   localparam int unsigned BMP_AW     = $clog2(ATTR_BASE);
   localparam int unsigned ATTR_AW    = $clog2(ATTR_SIZE);

   typedef struct packed {
      logic       in_display;
      logic [2:0] border;
      logic       flash;
      logic [2:0] bit_sel;
   } pix_stage_type;

endpackage

// ===== rtl/core/spectrum_display_pixel_generator.sv =====
// ---------------------------------------------------------------------------
// Spectrum display pixel generator
// Holds bitmap and attribute memories, the border latch and the flash timer,
// and turns pixel requests into palette indices.
//
//   Channel  Direction  Payload
//   req_     in         action, memory_address, write_data, screen_x, screen_y
//   rsp_     out        colour_index, in_display
//
// One transfer is accepted per cycle unless req_stall is high. A pixel
// request reads both memories at its transfer edge into the read stage, and
// its colour is then registered into the result stage, which offers it.
// Writes land in memory at the edge of their transfer, so a later request
// always sees them. Reset clears the border latch, frame counter, flash phase
// and all valid flags; the video memory is not cleared. A stalled result
// holds the read stage, which then stalls the request channel.
// ---------------------------------------------------------------------------
module spectrum_display_pixel_generator
   import sdpg_pkg::*;
#(
   parameter int unsigned FLASH_PERIOD = 25,
   parameter int unsigned TOP_BORDER   = 48,
   parameter int unsigned LEFT_BORDER  = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [12:0] req_memory_address,
   input  logic [7:0]  req_write_data,
   input  logic [8:0]  req_screen_x,
   input  logic [8:0]  req_screen_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_colour_index,
   output logic        rsp_in_display
);

   localparam logic [9:0] X_LO = 10'(LEFT_BORDER);
   localparam logic [9:0] X_HI = 10'(LEFT_BORDER + AREA_W);
   localparam logic [9:0] Y_LO = 10'(TOP_BORDER);
   localparam logic [9:0] Y_HI = 10'(TOP_BORDER + AREA_H);
   localparam logic [4:0] FLASH_LIMIT = 5'(FLASH_PERIOD);

   logic [7:0] bitmap_mem [ATTR_BASE];
   logic [7:0] attr_mem   [ATTR_SIZE];

   logic [7:0]    bits_rd_ff;
   logic [7:0]    attr_rd_ff;
   logic          s1_valid_ff;
   pix_stage_type s1_ff;
   pix_stage_type s1_in;
   logic          rsp_valid_ff;
   logic [3:0]    colour_ff;
   logic [3:0]    colour_in;
   logic          in_display_ff;
   logic [2:0]    border_ff;
   logic [4:0]    frame_count_ff;
   logic [4:0]    frame_count_in;
   logic          flash_ff;
   logic          flash_in;

   action_type    action;
   logic          accept;
   logic          advance;
   logic [9:0]    x_ext;
   logic [9:0]    y_ext;
   logic [9:0]    dx_full;
   logic [9:0]    dy_full;
   logic [7:0]    dx;
   logic [7:0]    dy;
   logic [7:0]    line;
   logic          in_area;
   logic [BMP_AW-1:0]  bmp_rd_addr;
   logic [ATTR_AW-1:0] attr_rd_addr;
   logic [12:0]   attr_off;
   logic [4:0]    frame_next;
   logic [3:0]    ink;
   logic [3:0]    paper;
   logic          pix_set;

   assign action  = action_type'(req_action);
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept  = req_valid && !req_stall;

   assign x_ext   = {1'b0, req_screen_x};
   assign y_ext   = {1'b0, req_screen_y};
   assign in_area = (x_ext >= X_LO) && (x_ext < X_HI) && (y_ext >= Y_LO) && (y_ext < Y_HI);
   assign dx_full = x_ext - X_LO;
   assign dy_full = y_ext - Y_LO;
   assign dx      = dx_full[7:0];
   assign dy      = dy_full[7:0];
   assign line    = {dy[7:6], dy[2:0], dy[5:3]};
   assign bmp_rd_addr  = BMP_AW'({line, dx[7:3]});
   assign attr_rd_addr = ATTR_AW'({dy[7:3], dx[7:3]});
   assign attr_off     = req_memory_address - 13'(ATTR_BASE);

   always_ff @(posedge clock) begin
      if (accept && action == ACT_MEM_WRITE && req_memory_address < 13'(ATTR_BASE)) begin
         bitmap_mem[BMP_AW'(req_memory_address)] <= req_write_data;
      end
      if (accept && action == ACT_PIXEL) begin
         bits_rd_ff <= bitmap_mem[bmp_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && action == ACT_MEM_WRITE && req_memory_address >= 13'(ATTR_BASE)
          && req_memory_address < 13'(VRAM_SIZE)) begin
         attr_mem[attr_off[ATTR_AW-1:0]] <= req_write_data;
      end
      if (accept && action == ACT_PIXEL) begin
         attr_rd_ff <= attr_mem[attr_rd_addr];
      end
   end

   always_comb begin
      frame_next = frame_count_ff + 5'd1;
      frame_count_in = frame_count_ff;
      flash_in = flash_ff;
      if (accept && action == ACT_FRAME_END) begin
         if (frame_next >= FLASH_LIMIT) begin
            frame_count_in = 5'd0;
            flash_in = !flash_ff;
         end else begin
            frame_count_in = frame_next;
         end
      end
   end

   always_comb begin
      s1_in.in_display = in_area;
      s1_in.border     = border_ff;
      s1_in.flash      = flash_ff;
      s1_in.bit_sel    = 3'd7 - dx[2:0];
   end

   always_comb begin
      ink     = {attr_rd_ff[6], attr_rd_ff[2:0]};
      paper   = {attr_rd_ff[6], attr_rd_ff[5:3]};
      pix_set = bits_rd_ff[s1_ff.bit_sel];
      if (s1_ff.flash && attr_rd_ff[7]) begin
         ink   = {attr_rd_ff[6], attr_rd_ff[5:3]};
         paper = {attr_rd_ff[6], attr_rd_ff[2:0]};
      end
      if (s1_ff.in_display) begin
         colour_in = pix_set ? ink : paper;
      end else begin
         colour_in = {1'b0, s1_ff.border};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff      <= 3'd0;
         frame_count_ff <= 5'd0;
         flash_ff       <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_count_ff <= frame_count_in;
         flash_ff       <= flash_in;
         if (accept && action == ACT_BORDER_WRITE) begin
            border_ff <= req_write_data[2:0];
         end
         if (accept) begin
            s1_valid_ff <= (action == ACT_PIXEL);
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && action == ACT_PIXEL) begin
         s1_ff <= s1_in;
      end
      if (advance && s1_valid_ff) begin
         colour_ff     <= colour_in;
         in_display_ff <= s1_ff.in_display;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_colour_index = colour_ff;
   assign rsp_in_display   = in_display_ff;

   a_flash_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      (flash_ff != $past(flash_ff)) |-> $past(accept && action == ACT_FRAME_END))
      else $error("Flash phase changed without a frame end transfer.");

   a_frame_count_range: assert property (@(posedge clock) disable iff (reset)
      frame_count_ff < FLASH_LIMIT)
      else $error("Frame counter reached the flash period.");

   a_stall_needs_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("Request stalled with the read stage empty.");

   a_border_not_bright: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !in_display_ff) |-> !colour_ff[3])
      else $error("Border colour carries the bright bit.");

endmodule

// ===== test/tb_spectrum_display_pixel_generator.sv =====
// ---------------------------------------------------------------------------
// Spectrum display pixel generator testbench
// Drives border writes, video memory writes, frame ends and pixel requests
// through the request channel. It predicts each palette index from its own
// copy of the video memory, border latch and flash timer, and compares every
// result transfer with the oldest outstanding prediction. Both channels idle
// at random in the first two of three phases, and the result channel holds
// off once for a long stretch so that the block fills up and stalls its requests.
// ---------------------------------------------------------------------------
module tb_spectrum_display_pixel_generator;
   import sdpg_pkg::*;

   localparam int unsigned FLASH_PERIOD = 25;
   localparam int unsigned TOP_BORDER   = 48;
   localparam int unsigned LEFT_BORDER  = 48;
   localparam int unsigned RANDOM_STEPS = 650;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   typedef struct {
      action_type  act;
      logic [12:0] addr;
      logic [7:0]  data;
      logic [8:0]  x;
      logic [8:0]  y;
   } display_req_type;

   typedef struct {
      logic [3:0] colour_index;
      logic       in_display;
   } pixel_colour_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = 2'd0;
   logic [12:0] req_memory_address = 13'd0;
   logic [7:0]  req_write_data = 8'd0;
   logic [8:0]  req_screen_x = 9'd0;
   logic [8:0]  req_screen_y = 9'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_colour_index;
   logic        rsp_in_display;

   display_req_type  pending_items[$];
   pixel_colour_type expected_pixels[$];
   display_req_type  drv_item;
   display_req_type  acc_item;
   pixel_colour_type exp_pix;
   pixel_colour_type pred_pix;

   bit           stim_written[VRAM_SIZE];
   logic [7:0]   shadow_vram[VRAM_SIZE];
   logic [2:0]   shadow_border = 3'd0;
   logic [4:0]   shadow_frames = 5'd0;
   logic         shadow_flash = 1'b0;

   int unsigned total_items = 0;
   int unsigned items_sent = 0;
   int unsigned items_accepted = 0;
   int unsigned pixels_checked = 0;
   int unsigned area_pixels = 0;
   int unsigned mem_writes = 0;
   int unsigned frame_ends = 0;
   int unsigned flash_changes = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit          pressure_done = 1'b0;

   spectrum_display_pixel_generator #(
      .FLASH_PERIOD (FLASH_PERIOD),
      .TOP_BORDER   (TOP_BORDER),
      .LEFT_BORDER  (LEFT_BORDER)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_memory_address (req_memory_address),
      .req_write_data     (req_write_data),
      .req_screen_x       (req_screen_x),
      .req_screen_y       (req_screen_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_colour_index   (rsp_colour_index),
      .rsp_in_display     (rsp_in_display)
   );

   always #5 clock = ~clock;

   function automatic bit in_bitmap_area(input int unsigned x, input int unsigned y);
      return x >= LEFT_BORDER && x < LEFT_BORDER + AREA_W &&
             y >= TOP_BORDER && y < TOP_BORDER + AREA_H;
   endfunction

   function automatic int unsigned bitmap_offset(input int unsigned dx, input int unsigned dy);
      logic [7:0] row;
      logic [7:0] line;
      row = dy[7:0];
      line = {row[7:6], row[2:0], row[5:3]};
      return int'(line) * 32 + dx / 8;
   endfunction

   function automatic int unsigned attr_offset(input int unsigned dx, input int unsigned dy);
      return ATTR_BASE + (dy / 8) * 32 + dx / 8;
   endfunction

   // Applies one accepted transfer to the shadow state; returns 1 where a
   // pixel result is due.
   function automatic bit advance_display(input display_req_type it,
                                          output pixel_colour_type res);
      int unsigned dx;
      int unsigned dy;
      logic [7:0]  bits;
      logic [7:0]  attr;
      logic [3:0]  ink;
      logic [3:0]  paper;
      logic [3:0]  tmp;
      res = '{colour_index: 4'd0, in_display: 1'b0};
      case (it.act)
         ACT_MEM_WRITE: begin
            if (it.addr < VRAM_SIZE) shadow_vram[it.addr] = it.data;
            mem_writes++;
            return 1'b0;
         end
         ACT_BORDER_WRITE: begin
            shadow_border = it.data[2:0];
            return 1'b0;
         end
         ACT_FRAME_END: begin
            frame_ends++;
            shadow_frames = shadow_frames + 5'd1;
            if (shadow_frames >= FLASH_PERIOD) begin
               shadow_frames = 5'd0;
               shadow_flash = ~shadow_flash;
               flash_changes++;
            end
            return 1'b0;
         end
         default: begin
            if (in_bitmap_area(it.x, it.y)) begin
               dx = it.x - LEFT_BORDER;
               dy = it.y - TOP_BORDER;
               bits = shadow_vram[bitmap_offset(dx, dy)];
               attr = shadow_vram[attr_offset(dx, dy)];
               ink = {attr[6], attr[2:0]};
               paper = {attr[6], attr[5:3]};
               if (shadow_flash && attr[7]) begin
                  tmp = ink;
                  ink = paper;
                  paper = tmp;
               end
               res.colour_index = bits[7 - (dx % 8)] ? ink : paper;
               res.in_display = 1'b1;
            end else begin
               res.colour_index = {1'b0, shadow_border};
               res.in_display = 1'b0;
            end
            return 1'b1;
         end
      endcase
   endfunction

   task automatic queue_item(input action_type act, input int unsigned addr,
                             input int unsigned data, input int unsigned x,
                             input int unsigned y);
      display_req_type it;
      it.act = act;
      it.addr = addr[12:0];
      it.data = data[7:0];
      it.x = x[8:0];
      it.y = y[8:0];
      if (act == ACT_MEM_WRITE && it.addr < VRAM_SIZE) stim_written[it.addr] = 1'b1;
      pending_items.push_back(it);
   endtask

   // A request inside the bitmap area first fills any byte it reads that has
   // not yet been written.
   task automatic queue_pixel(input int unsigned x, input int unsigned y);
      int unsigned bx;
      int unsigned by;
      int unsigned bmp;
      int unsigned att;
      bx = x % 512;
      by = y % 512;
      if (in_bitmap_area(bx, by)) begin
         bmp = bitmap_offset(bx - LEFT_BORDER, by - TOP_BORDER);
         att = attr_offset(bx - LEFT_BORDER, by - TOP_BORDER);
         if (!stim_written[bmp])
            queue_item(ACT_MEM_WRITE, bmp, $urandom_range(255), $urandom_range(511),
                       $urandom_range(511));
         if (!stim_written[att])
            queue_item(ACT_MEM_WRITE, att, $urandom_range(255), $urandom_range(511),
                       $urandom_range(511));
      end
      queue_item(ACT_PIXEL, $urandom_range(8191), $urandom_range(255), bx, by);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic int unsigned run_phase();
      int unsigned p;
      if (total_items == 0) return 0;
      p = (items_sent * 3) / total_items;
      return (p > 2) ? 2 : p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_items.size() != 0 &&
             $urandom_range(99) >=
                ((run_phase() == 0) ? 33 : (run_phase() == 1) ? 57 : 0)) begin
            drv_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_action <= drv_item.act;
            req_memory_address <= drv_item.addr;
            req_write_data <= drv_item.data;
            req_screen_x <= drv_item.x;
            req_screen_y <= drv_item.y;
            items_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!pressure_done && run_phase() == 2) begin
         pressure_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) <
                       ((run_phase() == 0) ? 57 : (run_phase() == 1) ? 33 : 0));
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, colour %0d display %0b",
                                         rsp_colour_index, rsp_in_display));
            end else begin
               exp_pix = expected_pixels.pop_front();
               if (rsp_colour_index !== exp_pix.colour_index)
                  report_mismatch($sformatf("colour_index %0d, expected %0d",
                                            rsp_colour_index, exp_pix.colour_index));
               if (rsp_in_display !== exp_pix.in_display)
                  report_mismatch($sformatf("in_display %0b, expected %0b",
                                            rsp_in_display, exp_pix.in_display));
               if (exp_pix.in_display) area_pixels++;
            end
            pixels_checked++;
         end
         if (req_valid && !req_stall) begin
            acc_item.act = action_type'(req_action);
            acc_item.addr = req_memory_address;
            acc_item.data = req_write_data;
            acc_item.x = req_screen_x;
            acc_item.y = req_screen_y;
            if (advance_display(acc_item, pred_pix)) expected_pixels.push_back(pred_pix);
            items_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out with %0d of %0d transfers accepted and %0d results outstanding.",
                  items_accepted, total_items, expected_pixels.size());
         $display("spectrum_display_pixel_generator verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned sel;
      // Border and frame edges, then known cells at the corners of the area.
      queue_pixel(0, 0);
      queue_item(ACT_BORDER_WRITE, 8191, 8'hFF, 0, 0);
      queue_pixel(351, 295);
      queue_pixel(511, 511);
      queue_pixel(LEFT_BORDER - 1, TOP_BORDER);
      queue_pixel(LEFT_BORDER, TOP_BORDER - 1);
      queue_pixel(LEFT_BORDER + AREA_W, 100);
      queue_pixel(100, TOP_BORDER + AREA_H);
      queue_item(ACT_MEM_WRITE, 0, 8'h80, 511, 511);
      queue_item(ACT_MEM_WRITE, ATTR_BASE, 8'h47, 0, 0);
      queue_pixel(LEFT_BORDER, TOP_BORDER);
      queue_pixel(LEFT_BORDER + 1, TOP_BORDER);
      queue_item(ACT_MEM_WRITE, 256, 8'hFF, 0, 0);
      queue_pixel(LEFT_BORDER, TOP_BORDER + 1);
      queue_item(ACT_MEM_WRITE, ATTR_BASE - 1, 8'h01, 0, 0);
      queue_item(ACT_MEM_WRITE, VRAM_SIZE - 1, 8'hBA, 0, 0);
      queue_pixel(LEFT_BORDER + AREA_W - 1, TOP_BORDER + AREA_H - 1);
      queue_item(ACT_MEM_WRITE, 8191, 8'h55, 0, 0);
      queue_item(ACT_MEM_WRITE, VRAM_SIZE, 8'h55, 0, 0);
      queue_item(ACT_FRAME_END, 0, 0, 0, 0);
      queue_item(ACT_BORDER_WRITE, 0, 8'hFA, 0, 0);
      queue_pixel(200, 10);

      for (int unsigned i = 0; i < RANDOM_STEPS; i++) begin
         sel = $urandom_range(99);
         if (sel < 50) begin
            queue_pixel(LEFT_BORDER + $urandom_range(AREA_W - 1),
                        TOP_BORDER + $urandom_range(AREA_H - 1));
         end else if (sel < 62) begin
            queue_pixel($urandom_range(511), $urandom_range(511));
         end else if (sel < 80) begin
            queue_item(ACT_MEM_WRITE,
                       ($urandom_range(4) != 0) ? $urandom_range(VRAM_SIZE - 1)
                                                : $urandom_range(8191),
                       $urandom_range(255), $urandom_range(511), $urandom_range(511));
         end else if (sel < 86) begin
            queue_item(ACT_BORDER_WRITE, $urandom_range(8191), $urandom_range(255),
                       $urandom_range(511), $urandom_range(511));
         end else if (sel < 88) begin
            for (int unsigned k = 0; k < FLASH_PERIOD; k++)
               queue_item(ACT_FRAME_END, $urandom_range(8191), $urandom_range(255),
                          $urandom_range(511), $urandom_range(511));
         end else begin
            queue_item(ACT_FRAME_END, $urandom_range(8191), $urandom_range(255),
                       $urandom_range(511), $urandom_range(511));
         end
      end
      total_items = pending_items.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < total_items) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transfers: %0d pixel results (%0d inside the bitmap area),",
               items_accepted, pixels_checked, area_pixels);
      $display("%0d memory writes and %0d frame ends with %0d flash phase changes.",
               mem_writes, frame_ends, flash_changes);
      if (error_count == 0) begin
         $display("spectrum_display_pixel_generator verification clean");
      end else begin
         $display("spectrum_display_pixel_generator verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sdpg_pkg.sv
rtl/core/spectrum_display_pixel_generator.sv
test/tb_spectrum_display_pixel_generator.sv
